// ----- hw/rtl/uer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Widths, codes, reset values and the divide-by-58 reciprocal of the ranger;
// its port checker shares the widths.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int unsigned TIMER_BITS = 16;
   localparam int unsigned DIST_BITS  = 10;
   localparam int unsigned TRIG_BITS  = 8;
   localparam int unsigned TOUT_BITS  = 16;
   localparam int unsigned NEAR_BITS  = 8;
   localparam int unsigned CSR_BITS   = 16;
   localparam int unsigned CMP_BITS   = 32;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Round-trip microseconds per centimeter.
   localparam int unsigned CM_DIVISOR = 58;
   // Reciprocal multiply: x / 58 == (x * DIV_MULT) >> DIV_SHIFT for every
   // TIMER_BITS-wide x, because the rounding error of DIV_MULT is below 64.
   localparam int unsigned DIV_SHIFT  = TIMER_BITS + 6;
   localparam longint unsigned DIV_MULT_L =
      ((64'd1 << DIV_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
   localparam logic [TIMER_BITS:0] DIV_MULT = (TIMER_BITS + 1)'(DIV_MULT_L);
   localparam int unsigned QUOT_BITS  = TIMER_BITS - 5;
   localparam int unsigned PROD_BITS  = 2 * TIMER_BITS + 1;

   localparam logic [DIST_BITS-1:0] LIMIT_RESET = 10'd400;
   localparam logic [TRIG_BITS-1:0] TRIG_RESET  = 8'd10;
   localparam logic [TOUT_BITS-1:0] TOUT_RESET  = 16'd30000;
   localparam logic [NEAR_BITS-1:0] NEAR_RESET  = 8'd2;

   // Request operation codes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TAKE  = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_DISTANCE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TRIGGER_HIGH   = 2'd1;
   localparam logic [1:0] CSR_ECHO_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_NEAR_ZERO      = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_RISE = 2'd2,
      PH_FALL = 2'd3
   } phase_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic [DIST_BITS-1:0] range_cm;
      logic                 distance_valid;
      logic                 new_distance;
      logic                 take_ok;
   } rsp_type;

endpackage : uer_pkg
`default_nettype wire

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A request's response is registered in the response register.
// Throughput: one request per cycle unless req_stall is high; the state update
// and divide-by-58 reciprocal multiply fit between state and response registers.
// A skid register takes one more request while the response is stalled.
// Reset is synchronous and active high; it restores the register defaults,
// idles the sequencer and empties the response and skid registers.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger/echo range sensor sequencer driven by microsecond tick requests,
// with start and take requests and a plain register write port.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,

   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [1:0]           req_op,
   input  wire                  req_echo_level,

   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 rsp_trigger_level,
   output logic                 rsp_busy_res,
   output logic [DIST_BITS-1:0] rsp_range_cm,
   output logic                 rsp_distance_valid,
   output logic                 rsp_new_distance,
   output logic                 rsp_take_ok,

   input  wire                  csr_write_enable,
   input  wire  [1:0]           csr_index,
   input  wire  [CSR_BITS-1:0]  csr_write_data
);

   // Configuration registers.
   logic [DIST_BITS-1:0]  limit_ff;
   logic [TRIG_BITS-1:0]  trig_ff;
   logic [TOUT_BITS-1:0]  tout_ff;
   logic [NEAR_BITS-1:0]  near_ff;

   // Sequencer state.
   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic                  trigger_ff, trigger_in;
   logic [DIST_BITS-1:0]  stored_ff, stored_in;
   logic                  fresh_ff, fresh_in;
   logic                  took;

   // Response path.
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   rsp_type               skid_ff;
   logic                  skid_valid_ff;

   logic                  accept;
   logic                  out_free;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic                  trig_done;
   logic                  timed_out;
   logic [PROD_BITS-1:0]  product;
   logic [QUOT_BITS-1:0]  quot;
   logic [DIST_BITS-1:0]  pulse_cm;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Tick arithmetic
   // ---------------------------------------------------------------------
   assign elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff
                                                  : elapsed_ff + 1'b1;
   assign trig_done = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(trig_ff)) ||
                      (elapsed_inc == TIMER_MAX);
   assign timed_out = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(tout_ff)) ||
                      (elapsed_inc == TIMER_MAX);

   assign product = PROD_BITS'(elapsed_inc) * PROD_BITS'(DIV_MULT);
   assign quot    = product[DIV_SHIFT +: QUOT_BITS];

   always_comb begin
      if (CMP_BITS'(quot) <= CMP_BITS'(near_ff)) begin
         pulse_cm = '0;
      end else if (CMP_BITS'(quot) > CMP_BITS'(limit_ff)) begin
         pulse_cm = limit_ff;
      end else begin
         pulse_cm = DIST_BITS'(quot);
      end
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      trigger_in = trigger_ff;
      stored_in  = stored_ff;
      fresh_in   = fresh_ff;
      took       = 1'b0;

      unique case (req_op)
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               elapsed_in = elapsed_inc;
            end
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_TRIG: begin
                  if (trig_done) begin
                     trigger_in = 1'b0;
                     elapsed_in = '0;
                     phase_in   = PH_RISE;
                  end
               end
               PH_RISE: begin
                  if (req_echo_level) begin
                     elapsed_in = '0;
                     phase_in   = PH_FALL;
                  end else if (timed_out) begin
                     stored_in  = limit_ff;
                     fresh_in   = 1'b1;
                     trigger_in = 1'b0;
                     phase_in   = PH_IDLE;
                  end
               end
               PH_FALL: begin
                  if (!req_echo_level || timed_out) begin
                     stored_in  = req_echo_level ? limit_ff : pulse_cm;
                     fresh_in   = 1'b1;
                     trigger_in = 1'b0;
                     phase_in   = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_START: begin
            if (phase_ff == PH_IDLE) begin
               fresh_in   = 1'b0;
               elapsed_in = '0;
               trigger_in = 1'b1;
               phase_in   = PH_TRIG;
            end
         end
         OP_TAKE: begin
            if (fresh_ff) begin
               fresh_in = 1'b0;
               took     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Response contents
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in.trigger_level  = trigger_in;
      rsp_in.busy_res       = (phase_in != PH_IDLE);
      rsp_in.range_cm       = stored_in;
      rsp_in.distance_valid = (stored_in != '0) && (stored_in < limit_ff);
      rsp_in.new_distance   = fresh_in;
      rsp_in.take_ok        = took;
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         trig_ff  <= TRIG_RESET;
         tout_ff  <= TOUT_RESET;
         near_ff  <= NEAR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISTANCE_LIMIT: limit_ff <= csr_write_data[DIST_BITS-1:0];
            CSR_TRIGGER_HIGH:   trig_ff  <= csr_write_data[TRIG_BITS-1:0];
            CSR_ECHO_TIMEOUT:   tout_ff  <= csr_write_data[TOUT_BITS-1:0];
            CSR_NEAR_ZERO:      near_ff  <= csr_write_data[NEAR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         trigger_ff <= 1'b0;
         stored_ff  <= LIMIT_RESET;
         fresh_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         trigger_ff <= trigger_in;
         stored_ff  <= stored_in;
         fresh_ff   <= fresh_in;
      end
   end

   // A request accepted while the response register is held goes to the skid
   // register, which then stalls the request side until it drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff  <= skid_valid_ff || accept;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (accept) begin
            rsp_ff <= rsp_in;
         end
      end else if (accept) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger_level  = rsp_ff.trigger_level;
   assign rsp_busy_res       = rsp_ff.busy_res;
   assign rsp_range_cm       = rsp_ff.range_cm;
   assign rsp_distance_valid = rsp_ff.distance_valid;
   assign rsp_new_distance   = rsp_ff.new_distance;
   assign rsp_take_ok        = rsp_ff.take_ok;

endmodule : ultrasonic_echo_ranger
`default_nettype wire

// ----- hw/rtl/uer_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger port checker
// Watches the ranger's ports and flags response-path and sequencer slips.
// ----------------------------------------------------------------------------
module uer_checker
   import uer_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire                 rsp_trigger_level,
   input wire                 rsp_busy_res,
   input wire [DIST_BITS-1:0] rsp_range_cm,
   input wire                 rsp_take_ok,
   input wire                 rsp_new_distance
);

   // A held response must not change under a stall.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_range_cm))
      else $error("response changed while stalled");

   // Reset leaves the response path empty and open for requests.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response path not empty after reset");

   // The skid register can only hold a request while a response is waiting.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty response register");

   // The trigger is only raised during a measurement.
   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_level |-> rsp_busy_res)
      else $error("trigger high while idle");

   // A successful take consumes the fresh result.
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_take_ok |-> !rsp_new_distance)
      else $error("fresh flag still set after a take");

endmodule : uer_checker

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_trigger_level (rsp_trigger_level),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_range_cm      (rsp_range_cm),
   .rsp_take_ok       (rsp_take_ok),
   .rsp_new_distance  (rsp_new_distance)
);
`default_nettype wire
